// ----- rtl/sqns_pkg.sv -----
// Package for the two-channel square and noise sound core.
// Holds widths, constants and register indexes; no dependencies.

package sqns_pkg;

    localparam int CountWidth  = 10;
    localparam int CtrlWidth   = 8;
    localparam int NoiseWidth  = 8;
    localparam int VolWidth    = 14;
    localparam int SampleWidth = 15;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 10;

    localparam logic [CountWidth-1:0] CountTop  = 10'd1023;
    localparam logic [CountWidth-1:0] NoToggle  = 10'd1022;
    localparam logic [NoiseWidth-1:0] NoiseTaps = 8'hB3;
    localparam logic [NoiseWidth-1:0] NoiseInit = 8'hFF;
    localparam logic [VolWidth-1:0]   VolCap    = 14'd8192;
    localparam logic [SampleWidth-1:0] SampleMax = 15'd16384;

    // Control register bit positions.
    localparam int CtrlCh1On    = 4;
    localparam int CtrlCh2On    = 5;
    localparam int CtrlNoiseOn  = 6;
    localparam int CtrlDacMode  = 7;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SOUND_CONTROL   = 2'd0,
        REG_CHANNEL1_RELOAD = 2'd1,
        REG_CHANNEL2_RELOAD = 2'd2
    } cfg_index_t;

    function automatic logic parity8(input logic [NoiseWidth-1:0] v);
        parity8 = ^v;
    endfunction

endpackage

// ----- rtl/two_channel_square_noise_sound_core.sv -----
// Two-channel square-wave and LFSR noise sound generator, top level.
// Depends on sqns_pkg for widths, constants and register indexes.

// One item carries a tick bit. A tick of 1 steps both 10-bit counters once
// (reload from the channel reload value on reaching 1023, toggle the square
// bit unless the reload value is 1022, and on channel 2 also step the 8-bit
// noise register with parity taps 0xB3); a tick of 0 leaves the state alone.
// Either way the item yields one mixed sample. DAC mode (control bit 7)
// forces both counters to their reload values and all outputs high on a
// tick. The core takes one item per clock unless stalled: the state update and
// the mixer sit between the state registers and a single output register, so
// an item appears on the output in the cycle after it is accepted, and a new
// item is taken in the same cycle in which the waiting sample leaves. in_stall
// rises only while a sample is held by out_stall. Configuration writes take
// effect at the clock edge where cfg_we is high; an index of 3 is ignored.
module two_channel_square_noise_sound_core
    import sqns_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    tick,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SampleWidth-1:0]  sample
);

    // Configuration registers.
    logic [CtrlWidth-1:0]  sound_control_reg;
    logic [CountWidth-1:0] channel1_reload_reg;
    logic [CountWidth-1:0] channel2_reload_reg;

    // Generator state.
    logic [CountWidth-1:0] count_one_reg,   count_one_next;
    logic                  square_one_reg,  square_one_next;
    logic [CountWidth-1:0] count_two_reg,   count_two_next;
    logic                  square_two_reg,  square_two_next;
    logic [NoiseWidth-1:0] noise_shift_reg, noise_shift_next;
    logic                  noise_bit_reg,   noise_bit_next;

    // Output register.
    logic                   out_valid_reg;
    logic [SampleWidth-1:0] sample_reg, sample_next;

    logic                  in_accept;
    logic [CountWidth-1:0] inc_one, inc_two;
    logic                  noise_fb;
    logic [VolWidth-1:0]   volume;

    // Accept when the output register is empty or drains this cycle.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_control_reg   <= '0;
            channel1_reload_reg <= '0;
            channel2_reload_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOUND_CONTROL:   sound_control_reg   <= cfg_data[CtrlWidth-1:0];
                REG_CHANNEL1_RELOAD: channel1_reload_reg <= cfg_data[CountWidth-1:0];
                REG_CHANNEL2_RELOAD: channel2_reload_reg <= cfg_data[CountWidth-1:0];
                default:             ;
            endcase
        end
    end

    // On a tick counters advance, reload at the top, squares toggle; DAC mode forces.
    always_comb
    begin
        inc_one          = count_one_reg + 1'b1;
        inc_two          = count_two_reg + 1'b1;
        noise_fb         = noise_bit_reg ^ parity8(noise_shift_reg & NoiseTaps);
        count_one_next   = count_one_reg;
        square_one_next  = square_one_reg;
        count_two_next   = count_two_reg;
        square_two_next  = square_two_reg;
        noise_shift_next = noise_shift_reg;
        noise_bit_next   = noise_bit_reg;
        if (tick)
        begin
            if (sound_control_reg[CtrlDacMode])
            begin
                // DAC mode: hold counters at reload, force outputs high.
                count_one_next   = channel1_reload_reg;
                count_two_next   = channel2_reload_reg;
                square_one_next  = 1'b1;
                square_two_next  = 1'b1;
                noise_shift_next = NoiseInit;
                noise_bit_next   = 1'b1;
            end
            else
            begin
                count_one_next = inc_one;
                if (inc_one == CountTop)
                begin
                    count_one_next = channel1_reload_reg;
                    if (channel1_reload_reg != NoToggle)
                    begin
                        square_one_next = !square_one_reg;
                    end
                end
                count_two_next = inc_two;
                if (inc_two == CountTop)
                begin
                    count_two_next = channel2_reload_reg;
                    if (channel2_reload_reg != NoToggle)
                    begin
                        // Channel 2 toggle also steps the noise register.
                        square_two_next  = !square_two_reg;
                        noise_bit_next   = noise_fb;
                        noise_shift_next = {noise_shift_reg[NoiseWidth-2:0], noise_fb};
                    end
                end
            end
        end
    end

    // Mixer: volume capped at 8192, added per active source; noise only if ch2 off.
    always_comb
    begin
        volume = {sound_control_reg[3:0], 10'd0};
        if (volume > VolCap)
        begin
            volume = VolCap;
        end
        sample_next = '0;
        if (sound_control_reg[CtrlCh1On] && square_one_next)
        begin
            sample_next = sample_next + SampleWidth'(volume);
        end
        if (sound_control_reg[CtrlCh2On])
        begin
            if (square_two_next)
            begin
                sample_next = sample_next + SampleWidth'(volume);
            end
        end
        else if (sound_control_reg[CtrlNoiseOn] && !noise_bit_next)
        begin
            sample_next = sample_next + SampleWidth'(volume);
        end
    end

    // State and output register: advance on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_one_reg   <= '0;
            square_one_reg  <= 1'b0;
            count_two_reg   <= '0;
            square_two_reg  <= 1'b0;
            noise_shift_reg <= NoiseInit;
            noise_bit_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                count_one_reg   <= count_one_next;
                square_one_reg  <= square_one_next;
                count_two_reg   <= count_two_next;
                square_two_reg  <= square_two_next;
                noise_shift_reg <= noise_shift_next;
                noise_bit_reg   <= noise_bit_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample_next;
        end
    end

`ifndef SYNTHESIS
    // Every accepted item shows up on the output next cycle.
    a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted item did not reach the output register");

    // A held sample is never overwritten by a new item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !in_accept)
        else $error("item accepted while output held");

    // The mixed level stays within two full volumes.
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample <= SampleMax))
        else $error("sample out of range");

    // A DAC-mode tick leaves the noise register and squares forced high.
    a_dac_force: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && tick && sound_control_reg[CtrlDacMode]) |=>
        (noise_shift_reg == NoiseInit && noise_bit_reg && square_one_reg
         && square_two_reg))
        else $error("DAC mode did not force generator state");
`endif

endmodule
